### rtl/css_length_to_fixed_px_defines.svh
// assertion macros shared by the css length to pixel design files
`ifndef CSS_LENGTH_TO_FIXED_PX_DEFINES_SVH
`define CSS_LENGTH_TO_FIXED_PX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLTFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CLTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cltfp_pkg.sv
// shared types, constants and the power-of-ten table for the length converter
package cltfp_pkg;

  localparam int MANT_W = 40;
  localparam int FC_W   = 3;
  localparam int SCL_W  = 16;
  localparam int DIV_W  = 20;

  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;
  localparam logic [7:0] CHR_DOT   = 8'd46;
  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_E     = 8'd101;
  localparam logic [7:0] CHR_M     = 8'd109;

  // value used when no digit was seen, and the scale for plain pixels (1.0 in Q8.8)
  localparam logic [MANT_W-1:0] DEFAULT_VALUE = MANT_W'(16);
  localparam logic [SCL_W-1:0]  PX_SCALE      = SCL_W'(256);

  typedef struct packed {
    logic [MANT_W-1:0] mantissa;
    logic [FC_W-1:0]   frac_count;
    logic              digit_seen;
    logic              unit_em;
  } job_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [FC_W-1:0] n);
    logic [DIV_W-1:0] r;
    case (n)
      3'd0:    r = DIV_W'(1);
      3'd1:    r = DIV_W'(10);
      3'd2:    r = DIV_W'(100);
      3'd3:    r = DIV_W'(1000);
      3'd4:    r = DIV_W'(10000);
      3'd5:    r = DIV_W'(100000);
      3'd6:    r = DIV_W'(1000000);
      default: r = DIV_W'(1);
    endcase
    return r;
  endfunction

endpackage

### rtl/cltfp_front.sv
// character scanner: builds the decimal mantissa and unit match, emits a job on end
module cltfp_front #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              is_end,
  output cltfp_pkg::job_t   job,
  output logic              job_push
);
  import cltfp_pkg::*;

  typedef enum logic [1:0] {SCAN_NUM, SCAN_UNIT, SCAN_DONE} scan_t;
  typedef enum logic [1:0] {NUM_INT, NUM_FRAC, NUM_STOP} num_t;
  typedef enum logic [1:0] {UNIT_NONE, UNIT_E, UNIT_EM, UNIT_OTHER} unit_t;

  scan_t             scan_phase, scan_phase_next;
  num_t              number_phase, number_phase_next;
  unit_t             unit_match, unit_match_next;
  logic              digit_seen, digit_seen_next;
  logic [MANT_W-1:0] mantissa, mantissa_next;
  logic [FC_W-1:0]   frac_count, frac_count_next;

  logic              is_digit;
  logic [MANT_W+3:0] mant_x10;
  logic [MANT_W-1:0] mant_pushed;
  unit_t             unit_stepped;

  always_comb begin
    is_digit = char_code inside {[CHR_ZERO:CHR_NINE]};
    // low nibble of an ascii digit is its value
    mant_x10 = ({4'b0, mantissa} << 3) + ({4'b0, mantissa} << 1)
             + (MANT_W+4)'(char_code[3:0]);
    mant_pushed = (|mant_x10[MANT_W+3:MANT_W]) ? '1 : mant_x10[MANT_W-1:0];

    case (unit_match)
      UNIT_NONE: unit_stepped = (char_code == CHR_E) ? UNIT_E : UNIT_OTHER;
      UNIT_E:    unit_stepped = (char_code == CHR_M) ? UNIT_EM : UNIT_OTHER;
      default:   unit_stepped = UNIT_OTHER;
    endcase
  end

  always_comb begin
    scan_phase_next   = scan_phase;
    number_phase_next = number_phase;
    unit_match_next   = unit_match;
    digit_seen_next   = digit_seen;
    mantissa_next     = mantissa;
    frac_count_next   = frac_count;
    if (accept) begin
      if (is_end) begin
        scan_phase_next   = SCAN_NUM;
        number_phase_next = NUM_INT;
        unit_match_next   = UNIT_NONE;
        digit_seen_next   = 1'b0;
        mantissa_next     = '0;
        frac_count_next   = '0;
      end else begin
        case (scan_phase)
          SCAN_NUM: begin
            if (is_digit) begin
              if (number_phase == NUM_INT) begin
                digit_seen_next = 1'b1;
                mantissa_next   = mant_pushed;
              end else if (number_phase == NUM_FRAC) begin
                digit_seen_next = 1'b1;
                if (frac_count < FC_W'(FRAC_DIGITS)) begin
                  mantissa_next   = mant_pushed;
                  frac_count_next = frac_count + 1'b1;
                end
              end
            end else if (char_code == CHR_DOT) begin
              number_phase_next = (number_phase == NUM_INT) ? NUM_FRAC : NUM_STOP;
            end else if (char_code != CHR_SPACE) begin
              scan_phase_next = SCAN_UNIT;
              unit_match_next = unit_stepped;
            end
          end
          SCAN_UNIT: begin
            if (char_code == CHR_SPACE) begin
              scan_phase_next = SCAN_DONE;
            end else begin
              unit_match_next = unit_stepped;
            end
          end
          default: begin
            // unit ended, rest of the string is ignored
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase   <= SCAN_NUM;
      number_phase <= NUM_INT;
      unit_match   <= UNIT_NONE;
      digit_seen   <= 1'b0;
      mantissa     <= '0;
      frac_count   <= '0;
    end else begin
      scan_phase   <= scan_phase_next;
      number_phase <= number_phase_next;
      unit_match   <= unit_match_next;
      digit_seen   <= digit_seen_next;
      mantissa     <= mantissa_next;
      frac_count   <= frac_count_next;
    end
  end

  assign job_push       = accept && is_end;
  assign job.mantissa   = mantissa;
  assign job.frac_count = frac_count;
  assign job.digit_seen = digit_seen;
  assign job.unit_em    = (unit_match == UNIT_EM);

endmodule

### rtl/cltfp_job_queue.sv
// two-entry job queue between the scanner and the scaler
`include "css_length_to_fixed_px_defines.svh"
module cltfp_job_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cltfp_pkg::job_t  wdata,
  output logic             full,
  input  logic             pop,
  output cltfp_pkg::job_t  rdata,
  output logic             valid
);
  import cltfp_pkg::*;

  logic [1:0] count;
  job_t       slot0, slot1;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b01: begin
          slot0 <= slot1;
          count <= count - 2'd1;
        end
        2'b10: begin
          if (count == 2'd0) begin
            slot0 <= wdata;
          end else begin
            slot1 <= wdata;
          end
          count <= count + 2'd1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            slot0 <= wdata;
          end else begin
            slot0 <= slot1;
            slot1 <= wdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `CLTFP_ASSERT_IMPLIES(a_no_push_when_full, full, !push, "job pushed into full queue")
  `CLTFP_ASSERT_IMPLIES(a_count_in_range, 1'b1, count != 2'd3, "job queue count out of range")

endmodule

### rtl/cltfp_scaler.sv
// scaler: multiply by the unit scale, long-divide by the power of ten, saturate
`include "css_length_to_fixed_px_defines.svh"
module cltfp_scaler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  cltfp_pkg::job_t             job,
  output logic                        job_pop,
  input  logic [cltfp_pkg::SCL_W-1:0] em_scale,
  output logic                        res_valid,
  input  logic                        pop,
  output logic [31:0]                 px_value,
  output logic                        invalid
);
  import cltfp_pkg::*;

  localparam int PROD_W = MANT_W + SCL_W;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

  state_t            state;
  logic [MANT_W-1:0] mult_a;
  logic [SCL_W-1:0]  mult_b;
  logic [FC_W-1:0]   fc;
  logic              sat;
  logic              inv;
  logic [PROD_W-1:0] dividend;
  logic [PROD_W-1:0] quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [CNT_W-1:0]  bit_cnt;

  logic [DIV_W:0]    trial;
  logic              ge;
  logic [DIV_W:0]    trial_sub;
  logic              load;

  always_comb begin
    trial     = {rem, dividend[PROD_W-1]};
    ge        = (trial >= {1'b0, divisor});
    trial_sub = trial - {1'b0, divisor};
  end

  assign job_pop = (state == ST_IDLE) && job_valid;
  assign load    = (state == ST_DONE) && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            mult_a <= job.digit_seen ? job.mantissa : DEFAULT_VALUE;
            mult_b <= job.unit_em ? em_scale : PX_SCALE;
            fc     <= job.digit_seen ? job.frac_count : '0;
            sat    <= job.digit_seen && (&job.mantissa);
            inv    <= !job.digit_seen;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          dividend <= mult_a * mult_b;
          divisor  <= pow10(fc);
          rem      <= '0;
          quo      <= '0;
          bit_cnt  <= CNT_W'(PROD_W - 1);
          state    <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          rem      <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
          quo      <= {quo[PROD_W-2:0], ge};
          dividend <= {dividend[PROD_W-2:0], 1'b0};
          bit_cnt  <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (load) begin
        px_value  <= (sat || (|quo[PROD_W-1:32])) ? '1 : quo[31:0];
        invalid   <= inv;
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  `CLTFP_ASSERT_IMPLIES(a_rem_below_divisor, state == ST_DIV, rem < divisor,
                        "division remainder not below divisor")
  `CLTFP_ASSERT_NEXT(a_load_gives_result, load, res_valid && state == ST_IDLE,
                     "finished item not placed in result register")

endmodule

### rtl/css_length_to_fixed_px.sv
// top level: css length string to unsigned q24.8 pixel converter
// character items are taken one per cycle while the job queue has room (two entries)
// an end item's job passes the queue, then the scaler steps through start, multiply,
// 56 long-division steps (one quotient bit a cycle) and finish; finish waits on pop
// the scaler works on one end item at a time and takes the next job once it is done
// reset (rst, synchronous) clears scanner, job queue and result, sets em_scale to 16.0
module css_length_to_fixed_px #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input side, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        is_end,
  // result side, queue style
  output logic        empty,
  input  logic        pop,
  output logic [31:0] px_value,
  output logic        invalid,
  // configuration: pixels per em, unsigned q8.8
  input  logic        em_to_px_we,
  input  logic [15:0] em_to_px
);
  import cltfp_pkg::*;

  // scale register for the em unit
  logic [SCL_W-1:0] em_scale;

  logic  accept;
  logic  job_push;
  job_t  front_job;
  logic  q_full;
  logic  q_valid;
  job_t  q_job;
  logic  q_pop;
  logic  res_valid;

  // front side stalls only when the job queue is full
  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_scale <= SCL_W'(4096);
    end else if (em_to_px_we) begin
      em_scale <= em_to_px;
    end
  end

  // front: per-character scan, emits one job per end item
  cltfp_front #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .is_end    (is_end),
    .job       (front_job),
    .job_push  (job_push)
  );

  // short queue so the scanner keeps taking characters while the scaler works
  cltfp_job_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_job),
    .valid (q_valid)
  );

  // back: scale, divide, saturate, hold result until popped
  cltfp_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .em_scale  (em_scale),
    .res_valid (res_valid),
    .pop       (pop),
    .px_value  (px_value),
    .invalid   (invalid)
  );

endmodule

### tb/sv/css_length_px_checker.sv
// result checker for the css length to pixel converter: predicts each item and compares
module css_length_px_checker #(
  parameter int FRAC_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  char_code,
  input  logic        is_end,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] px_value,
  input  logic        invalid,
  input  logic        em_to_px_we,
  input  logic [15:0] em_to_px,
  output int          waiting,
  output int          errors
);
  import cltfp_pkg::*;

  localparam logic [SCL_W-1:0]  EM_RESET = 16'h1000;
  localparam logic [MANT_W-1:0] MANT_SAT = '1;

  typedef enum logic [1:0] {SCAN_NUMBER, SCAN_UNIT, SCAN_DONE} scan_e;
  typedef enum logic [1:0] {NUM_INT, NUM_FRAC, NUM_STOP} num_e;
  typedef enum logic [1:0] {UNIT_NONE, UNIT_E, UNIT_EM, UNIT_OTHER} unit_e;

  typedef struct packed {
    logic [31:0] px;
    logic        bad;
  } px_result_t;

  scan_e             scan;
  num_e              num;
  unit_e             unit;
  logic              seen;
  logic [MANT_W-1:0] mant;
  logic [FC_W-1:0]   kept_frac;
  logic [SCL_W-1:0]  scale;
  px_result_t        px_expected_q[$];
  px_result_t        want;

  function automatic unit_e next_unit(input unit_e u, input logic [7:0] c);
    case (u)
      UNIT_NONE: return (c == CHR_E) ? UNIT_E : UNIT_OTHER;
      UNIT_E:    return (c == CHR_M) ? UNIT_EM : UNIT_OTHER;
      default:   return UNIT_OTHER;
    endcase
  endfunction

  function automatic logic [MANT_W-1:0] shift_in_digit(input logic [MANT_W-1:0] m,
                                                       input logic [7:0] c);
    logic [63:0] wide;
    wide = 64'(m) * 64'd10 + 64'(c - CHR_ZERO);
    return (wide > 64'(MANT_SAT)) ? MANT_SAT : wide[MANT_W-1:0];
  endfunction

  task automatic clear_length();
    scan      = SCAN_NUMBER;
    num       = NUM_INT;
    unit      = UNIT_NONE;
    seen      = 1'b0;
    mant      = '0;
    kept_frac = '0;
  endtask

  task automatic scan_char(input logic [7:0] c);
    case (scan)
      SCAN_NUMBER: begin
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
          if (num == NUM_INT) begin
            seen = 1'b1;
            mant = shift_in_digit(mant, c);
          end else if (num == NUM_FRAC) begin
            seen = 1'b1;
            if (kept_frac < FRAC_DIGITS) begin
              mant = shift_in_digit(mant, c);
              kept_frac++;
            end
          end
        end else if (c == CHR_DOT) begin
          if (num == NUM_INT) num = NUM_FRAC;
          else num = NUM_STOP;
        end else if (c != CHR_SPACE) begin
          scan = SCAN_UNIT;
          unit = next_unit(unit, c);
        end
      end
      SCAN_UNIT: begin
        if (c == CHR_SPACE) scan = SCAN_DONE;
        else unit = next_unit(unit, c);
      end
      default: ;
    endcase
  endtask

  // value * scale / 10^frac, floored and saturated to 32 bits
  function automatic px_result_t length_to_px();
    logic [63:0] value;
    logic [63:0] divisor;
    logic [63:0] quotient;
    px_result_t  r;
    r.bad = !seen;
    if (seen && mant == MANT_SAT) begin
      r.px = '1;
    end else begin
      value   = seen ? 64'(mant) : 64'(DEFAULT_VALUE);
      divisor = 64'd1;
      if (seen) for (int i = 0; i < kept_frac; i++) divisor = divisor * 64'd10;
      quotient = (value * ((unit == UNIT_EM) ? 64'(scale) : 64'(PX_SCALE))) / divisor;
      r.px = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[31:0];
    end
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      scale = EM_RESET;
      clear_length();
      px_expected_q.delete();
    end else begin
      if (em_to_px_we) scale = em_to_px;
      if (pop && !empty) begin
        if (px_expected_q.size() == 0) begin
          $display("%0t: item with nothing expected, px_value %h invalid %b",
                   $time, px_value, invalid);
          errors++;
        end else begin
          want = px_expected_q.pop_front();
          if (px_value !== want.px) begin
            $display("%0t: px_value expected %h actual %h", $time, want.px, px_value);
            errors++;
          end
          if (invalid !== want.bad) begin
            $display("%0t: invalid expected %b actual %b", $time, want.bad, invalid);
            errors++;
          end
        end
      end
      if (push && !full) begin
        if (is_end) begin
          px_expected_q.push_back(length_to_px());
          clear_length();
        end else begin
          scan_char(char_code);
        end
      end
    end
    waiting <= px_expected_q.size();
  end

endmodule

### tb/sv/css_length_to_fixed_px_tb.sv
// top of the css length to pixel testbench: stimulus, receiver, verdict
module css_length_to_fixed_px_tb;
  import cltfp_pkg::*;

  localparam int FRAC_DIGITS    = 4;
  localparam int PHASE_ITEMS    = 325;       // random items per phase, six phases
  localparam int SETTLE_CYCLES  = 70;        // settle time once every expected result is back
  localparam int RX_HOLD_CYCLES = 2000;      // long receiver hold-off in the pressure phase
  localparam int TIMEOUT        = 10_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  char_code;
  logic        is_end;
  logic        empty;
  logic        pop;
  logic [31:0] px_value;
  logic        invalid;
  logic        em_to_px_we;
  logic [15:0] em_to_px;

  int          waiting;
  int          errors;
  int          tx_pct;        // sender idle chance per cycle, in percent
  int          rx_pct;        // receiver stall chance per cycle, in percent
  logic        rx_hold_req;
  logic        rx_hold_done;
  int          phase_items;
  logic [7:0]  text_q[$];     // characters of the length string being built

  always #5 clk = ~clk;

  css_length_to_fixed_px #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .is_end     (is_end),
    .empty      (empty),
    .pop        (pop),
    .px_value   (px_value),
    .invalid    (invalid),
    .em_to_px_we(em_to_px_we),
    .em_to_px   (em_to_px)
  );

  css_length_px_checker #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_px_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_code  (char_code),
    .is_end     (is_end),
    .empty      (empty),
    .pop        (pop),
    .px_value   (px_value),
    .invalid    (invalid),
    .em_to_px_we(em_to_px_we),
    .em_to_px   (em_to_px),
    .waiting    (waiting),
    .errors     (errors)
  );

  // safety net in case the block hangs
  initial begin
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off once the stimulus asks for it
  initial begin
    pop <= 1'b0;
    rx_hold_done <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        // the sender keeps offering items meanwhile, so the block backs up and goes full
        repeat (RX_HOLD_CYCLES) begin
          pop <= 1'b0;
          @(posedge clk);
        end
        rx_hold_done <= 1'b1;
      end
      pop <= ($urandom_range(99) >= rx_pct);
    end
  end

  // one item, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_item(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < tx_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    is_end    <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    phase_items++;
  endtask

  // the built string, then an end item whose character byte is junk
  task automatic send_length();
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_literal(input string s);
    text_q.delete();
    add_text(s);
    send_length();
  endtask

  // decimal digits, now and then with a space in between (spaces get dropped)
  task automatic add_digits(input int n);
    repeat (n) begin
      text_q.push_back(CHR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(99) < 6) text_q.push_back(CHR_SPACE);
    end
  endtask

  // mostly well-formed lengths with random content, some plain noise
  task automatic build_random_length();
    int pick;
    int n;
    text_q.delete();
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise: any bytes, possibly none at all
      repeat ($urandom_range(6)) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2)) text_q.push_back(CHR_SPACE);
      // integer part: mostly short, sometimes long enough to overflow
      pick = $urandom_range(99);
      if (pick < 8) n = 0;
      else if (pick < 72) n = $urandom_range(1, 3);
      else if (pick < 88) n = $urandom_range(4, 8);
      else if (pick < 96) n = $urandom_range(9, 12);
      else n = $urandom_range(13, 15);
      add_digits(n);
      // fraction part, past the kept digit count at times, with an odd second dot
      if ($urandom_range(99) < 55) begin
        text_q.push_back(CHR_DOT);
        add_digits($urandom_range(7));
        if ($urandom_range(99) < 8) begin
          text_q.push_back(CHR_DOT);
          add_digits($urandom_range(1, 3));
        end
      end
      // unit: em scales, the rest leave the scale at one
      pick = $urandom_range(99);
      if (pick < 35) add_text("em");
      else if (pick < 55) add_text("px");
      else if (pick < 62) add_text("e");
      else if (pick < 68) add_text("emm");
      else if (pick < 74) text_q.push_back(8'($urandom_range(255)));
      else if (pick < 78) add_text("m");
      // trailing junk after a space is ignored by the block once a unit has been scanned
      if ($urandom_range(99) < 15) begin
        text_q.push_back(CHR_SPACE);
        repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // sender stops until every expected item is back, then lets the block settle
  task automatic wait_idle(input int extra);
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_scale(input logic [15:0] v);
    em_to_px_we <= 1'b1;
    em_to_px    <= v;
    @(posedge clk);
    em_to_px_we <= 1'b0;
  endtask

  initial begin
    rst         <= 1'b1;
    push        <= 1'b0;
    char_code   <= 8'd0;
    is_end      <= 1'b0;
    em_to_px_we <= 1'b0;
    em_to_px    <= 16'd0;
    rx_pct      <= 0;
    rx_hold_req <= 1'b0;
    tx_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed lengths under the reset scale of 16 px per em
    text_q.delete();
    send_length();                          // empty string: default 16, invalid
    send_literal("1.5em");
    send_literal(" 7.");                    // leading space, dot with no fraction
    send_literal("1..5");                   // second dot stops the number
    send_literal("em");                     // no digit, unit still applies
    text_q = {8'hFF};                       // top byte as a one-character unit
    send_length();
    text_q = {CHR_ZERO + 8'd5, 8'h00};      // zero byte as a unit
    send_length();
    wait_idle(SETTLE_CYCLES);

    // random phases: scale extremes and idle patterns, pressure at the end
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          set_scale(16'hFFFF);
          tx_pct = 31;
          rx_pct <= 77;
        end
        1: begin
          set_scale(16'h0000);
          tx_pct = 31;
          rx_pct <= 77;
        end
        2: begin
          set_scale(16'h0100);
          tx_pct = 77;
          rx_pct <= 31;
        end
        3: begin
          set_scale(16'($urandom));
          tx_pct = 77;
          rx_pct <= 31;
        end
        4: begin
          set_scale(16'h0001);
          tx_pct = 0;
          rx_pct <= 0;
        end
        default: begin
          // no idling, but the receiver holds off for a long stretch
          set_scale(16'($urandom));
          tx_pct = 0;
          rx_pct <= 0;
          rx_hold_req <= 1'b1;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_random_length();
        send_length();
      end
      wait_idle(SETTLE_CYCLES);
    end

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/cltfp_pkg.sv
rtl/cltfp_front.sv
rtl/cltfp_job_queue.sv
rtl/cltfp_scaler.sv
rtl/css_length_to_fixed_px.sv
tb/sv/css_length_px_checker.sv
tb/sv/css_length_to_fixed_px_tb.sv
